// ----- rtl/core/alu32_pkg.sv -----
// ----------------------------------------------------------------------------
// alu32_pkg: shared types and constants
// Operation codes, decoded-operation struct and queue sizing for the ALU.
// ----------------------------------------------------------------------------
package alu32_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned KindW  = 4;
    localparam int unsigned ShiftW = 5;
    localparam int unsigned QDepth = 2;

    typedef enum logic [KindW-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_NOT = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9
    } t_op;

    // Operation class chosen by the front end
    typedef enum logic [1:0] {
        CLS_ZERO  = 2'd0,  // unused code, result 0
        CLS_LOGIC = 2'd1,  // result formed combinationally at issue
        CLS_MUL   = 2'd2,
        CLS_DIV   = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic [KindW-1:0] kind;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             z;
        logic             n;
        logic             c;
        logic             v;
        logic             err;
    } t_res;

endpackage

// ----- rtl/core/alu32_front.sv -----
// ----------------------------------------------------------------------------
// alu32_front: intake and classification
// Registers incoming transactions, tags each with its class, and queues them.
// ----------------------------------------------------------------------------
module alu32_front import alu32_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KindW-1:0] i_kind,
    input  logic [DataW-1:0] i_operand_a,
    input  logic [DataW-1:0] i_operand_b,
    output logic             o_q_valid,
    input  logic             i_q_pop,
    output t_item            o_q_item
);

    localparam int unsigned PtrW = $clog2(QDepth);

    t_item           r_mem [QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt;
    t_item           n_item;
    logic            push, pop;

    always_comb begin
        n_item.kind = i_kind;
        n_item.a    = i_operand_a;
        n_item.b    = i_operand_b;
        case (i_kind)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
            OP_NOT, OP_SHL, OP_SHR: n_item.cls = CLS_LOGIC;
            OP_MUL:                 n_item.cls = CLS_MUL;
            OP_DIV:                 n_item.cls = CLS_DIV;
            default:                n_item.cls = CLS_ZERO;
        endcase
    end

    assign o_stall   = (r_cnt == (PtrW+1)'(QDepth));
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW+1)'(QDepth)) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PtrW+1)'(QDepth)) |-> o_stall) else $error("full without stall");

endmodule

// ----- rtl/core/alu32_div.sv -----
// ----------------------------------------------------------------------------
// alu32_div: pipelined unsigned divider
// Restoring, one quotient bit per stage, 32 stages, 1 per cycle if i_en.
// ----------------------------------------------------------------------------
module alu32_div import alu32_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DataW-1:0] i_a,
    input  logic [DataW-1:0] i_b,
    output logic [DataW-1:0] o_q
);

    // stage s+1 registers; the last stage only keeps the quotient
    logic [DataW-1:0] r_rem [1:DataW-1];
    logic [DataW-1:0] r_num [1:DataW];
    logic [DataW-1:0] r_den [1:DataW-1];

    for (genvar s = 0; s < DataW; s++) begin : g_stage
        logic [DataW-1:0] rem_in, num_in, den_in;
        logic [DataW:0]   trial, diff;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_a;
            assign den_in = i_b;
        end else begin : g_next
            assign rem_in = r_rem[s];
            assign num_in = r_num[s];
            assign den_in = r_den[s];
        end

        always_comb begin
            trial = {rem_in, num_in[DataW-1]};
            diff  = trial - {1'b0, den_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= {num_in[DataW-2:0], ~diff[DataW]};
            end
        end

        if (s < DataW-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
                    r_den[s+1] <= den_in;
                end
            end
        end
    end

    assign o_q = r_num[DataW];

endmodule

// ----- rtl/core/alu32_back.sv -----
// ----------------------------------------------------------------------------
// alu32_back: execution pipeline
// Lock-step pipeline that stalls as a whole: logic results ride along the divider's stages.
// ----------------------------------------------------------------------------
module alu32_back import alu32_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_item            i_q_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_res             o_res
);

    localparam int unsigned Lat = DataW + 1;  // issue reg + divider stages

    // per-stage sideband: class, early result, carry, overflow, div-by-zero
    typedef struct packed {
        t_cls             cls;
        logic [DataW-1:0] val;
        logic             c;
        logic             v;
        logic             dz;
    } t_side;

    logic  r_v  [Lat+1];
    t_side r_sb [Lat+1];
    logic  adv;
    logic [DataW-1:0] r_mul_a, r_mul_b;
    logic [DataW-1:0] r_mul_p [DataW];
    logic [DataW-1:0] r_da, r_db;
    logic [DataW-1:0] quo;
    t_side s0;
    logic [DataW:0] sum, dif;
    logic [ShiftW-1:0] sh;

    // whole pipe advances unless the output is held
    assign adv     = !(r_v[Lat] && i_stall);
    assign o_q_pop = adv;

    always_comb begin
        sh    = i_q_item.b[ShiftW-1:0];
        sum   = {1'b0, i_q_item.a} + {1'b0, i_q_item.b};
        dif   = {1'b0, i_q_item.a} - {1'b0, i_q_item.b};
        s0.cls = i_q_item.cls;
        s0.c   = 1'b0;
        s0.v   = 1'b0;
        s0.dz  = (i_q_item.cls == CLS_DIV) && (i_q_item.b == '0);
        case (i_q_item.kind)
            OP_ADD: begin
                s0.val = sum[DataW-1:0];
                s0.c   = sum[DataW];
                s0.v   = (i_q_item.a[DataW-1] ^ sum[DataW-1]) &
                         (i_q_item.b[DataW-1] ^ sum[DataW-1]);
            end
            OP_SUB: begin
                s0.val = dif[DataW-1:0];
                s0.c   = dif[DataW];
                s0.v   = (i_q_item.a[DataW-1] ^ i_q_item.b[DataW-1]) &
                         (i_q_item.a[DataW-1] ^ dif[DataW-1]);
            end
            OP_AND:  s0.val = i_q_item.a & i_q_item.b;
            OP_OR:   s0.val = i_q_item.a | i_q_item.b;
            OP_XOR:  s0.val = i_q_item.a ^ i_q_item.b;
            OP_NOT:  s0.val = ~i_q_item.a;
            OP_SHL:  s0.val = i_q_item.a << sh;
            OP_SHR:  s0.val = i_q_item.a >> sh;
            default: s0.val = '0;
        endcase
    end

    // stage 0 registers the operands for the long units; sideband shifts along
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb[0] <= s0;
            for (int k = 1; k <= Lat; k++) r_sb[k] <= r_sb[k-1];
            r_mul_a <= i_q_item.a;
            r_mul_b <= i_q_item.b;
            r_da    <= i_q_item.a;
            r_db    <= i_q_item.b;
        end
    end

    // multiplier: 32x32 low product, registered, then delayed to match
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul_p[0] <= r_mul_a * r_mul_b;
            for (int k = 1; k < DataW; k++) r_mul_p[k] <= r_mul_p[k-1];
        end
    end

    alu32_div u_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_da),
        .i_b   (r_db),
        .o_q   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Lat; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_q_valid;
            for (int k = 1; k <= Lat; k++) r_v[k] <= r_v[k-1];
        end
    end

    // result formed from the last stage; r_quo lines up with r_sb[Lat]
    t_res  n_res;
    logic [DataW-1:0] r_quo;
    logic [DataW-1:0] r_mp;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quo <= quo;
            r_mp  <= r_mul_p[DataW-1];
        end
    end

    always_comb begin
        n_res = '0;
        case (r_sb[Lat].cls)
            CLS_MUL:   n_res.value = r_mp;
            CLS_DIV:   n_res.value = r_sb[Lat].dz ? '0 : r_quo;
            CLS_LOGIC: n_res.value = r_sb[Lat].val;
            default:   n_res.value = '0;
        endcase
        n_res.err = r_sb[Lat].dz;
        n_res.z   = !r_sb[Lat].dz && (n_res.value == '0);
        n_res.n   = !r_sb[Lat].dz && n_res.value[DataW-1];
        n_res.c   = r_sb[Lat].c;
        n_res.v   = r_sb[Lat].v;
    end

    assign o_valid = r_v[Lat];
    assign o_res   = n_res;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_dz_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.err) |-> (o_res.value == '0 && !o_res.z && !o_res.c))
        else $error("div error flags");
    a_pop_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop == adv) else $error("pop mismatch");

endmodule

// ----- rtl/core/alu_32bit_with_flags.sv -----
// ----------------------------------------------------------------------------
// alu_32bit_with_flags: 32-bit ALU with NZCV flags
// Path: accepting edge, queue, issue register, multiplier/32-stage divider
//   pipe (fully pipelined), result register; the same for every op.
// Throughput: one transaction per cycle unless the output is held.
// Reset: synchronous, active low; empties the queue and the pipeline valids.
// ----------------------------------------------------------------------------
module alu_32bit_with_flags import alu32_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KindW-1:0] i_kind,
    input  logic [DataW-1:0] i_operand_a,
    input  logic [DataW-1:0] i_operand_b,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [DataW-1:0] o_value,
    output logic             o_zero_flag,
    output logic             o_negative_flag,
    output logic             o_carry_flag,
    output logic             o_overflow_flag,
    output logic             o_div_error
);

    // front end: classification and short queue
    logic  q_valid, q_pop;
    t_item q_item;
    t_res  res;

    alu32_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_item    (q_item)
    );

    // back end: lock-step pipeline, stalls as a whole when output is held
    alu32_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    assign o_value         = res.value;
    assign o_zero_flag     = res.z;
    assign o_negative_flag = res.n;
    assign o_carry_flag    = res.c;
    assign o_overflow_flag = res.v;
    assign o_div_error     = res.err;

endmodule
